// ===== design/pdc_pkg.sv =====
package pdc_pkg;

    localparam int ADDR_W = 5;
    localparam int ACC_W  = 58;
    localparam int PROD_W = 38;
    localparam int INT_W  = 40;
    localparam int ERR_W  = 17;
    localparam int OUT_W  = 24;
    localparam int PC_W   = 3;

    typedef enum logic [2:0] {
        REG_ENABLE  = 3'd0,
        REG_KP      = 3'd1,
        REG_KI      = 3'd2,
        REG_KD      = 3'd3,
        REG_DT      = 3'd4,
        REG_EPSILON = 3'd5,
        REG_OUT_MAX = 3'd6,
        REG_OUT_MIN = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_DT_ERR,
        MUL_KP_ERR,
        MUL_KD_DE,
        MUL_KI_LO,
        MUL_KI_HI
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_CLR,
        ACC_ADD0,
        ACC_ADD16,
        ACC_ADD20
    } acc_op_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_INTEG,
        ACT_OUT,
        ACT_ZERO
    } act_t;

    typedef enum logic {
        JMP_NONE,
        JMP_DIS
    } jmp_t;

    typedef struct packed {
        mul_sel_t         mul;
        acc_op_t          acc;
        act_t             act;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    localparam logic [PC_W-1:0] STEP_ZERO = 3'd7;

    function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
        ctrl_t c;
        c = '{MUL_DT_ERR, ACC_HOLD, ACT_NONE, JMP_NONE, '0};
        unique case (pc)
            3'd0: c = '{MUL_DT_ERR, ACC_HOLD,  ACT_NONE,  JMP_DIS,  STEP_ZERO};
            3'd1: c = '{MUL_KP_ERR, ACC_CLR,   ACT_INTEG, JMP_NONE, '0};
            3'd2: c = '{MUL_KD_DE,  ACC_ADD16, ACT_NONE,  JMP_NONE, '0};
            3'd3: c = '{MUL_KI_LO,  ACC_ADD16, ACT_NONE,  JMP_NONE, '0};
            3'd4: c = '{MUL_KI_HI,  ACC_ADD0,  ACT_NONE,  JMP_NONE, '0};
            3'd5: c = '{MUL_DT_ERR, ACC_ADD20, ACT_NONE,  JMP_NONE, '0};
            3'd6: c = '{MUL_DT_ERR, ACC_HOLD,  ACT_OUT,   JMP_NONE, '0};
            3'd7: c = '{MUL_DT_ERR, ACC_HOLD,  ACT_ZERO,  JMP_NONE, '0};
            default: c = '{MUL_DT_ERR, ACC_HOLD, ACT_NONE, JMP_NONE, '0};
        endcase
        return c;
    endfunction

endpackage

// ===== design/pid_controller_deadband_clamp.sv =====
// channel   | direction | tdata                                | tuser
// s_axis    | request   | [15:0] target, [31:16] measured      | [0] clear_history
// m_axis    | result    | [23:0] drive                         | [0] clamped
// apb       | config    | 8 registers at byte address 4*i      | -
//
// a request runs 7 program steps if enabled, only step 0 and the zero step if disabled;
// the steps are set by the single shared 17x21 multiplier the program walks through
// reset clears registers to their defaults and zeroes integral and last error
// a new request is taken as soon as the program ends, even while a result waits
// the final step stalls only if the previous result has not yet been taken
module pid_controller_deadband_clamp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [31:0]                   s_axis_tdata,  // target, measured
    input  logic [0:0]                    s_axis_tuser,  // clear_history
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [23:0]                   m_axis_tdata,  // drive
    output logic [0:0]                    m_axis_tuser,  // clamped
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic                                enable_reg;
    logic [15:0]                         kp_reg;
    logic [15:0]                         ki_reg;
    logic [15:0]                         kd_reg;
    logic [15:0]                         dt_reg;
    logic [15:0]                         eps_reg;
    logic signed [pdc_pkg::OUT_W-1:0]    out_max_reg;
    logic signed [pdc_pkg::OUT_W-1:0]    out_min_reg;

    logic                                busy_reg;
    logic [pdc_pkg::PC_W-1:0]            pc_reg;
    logic [pdc_pkg::PC_W-1:0]            pc_next;
    logic signed [pdc_pkg::ERR_W-1:0]    err_reg;
    logic signed [pdc_pkg::ERR_W-1:0]    err_next;
    logic signed [pdc_pkg::ERR_W-1:0]    last_err_reg;
    logic signed [pdc_pkg::ERR_W-1:0]    last_err_next;
    logic signed [pdc_pkg::INT_W-1:0]    integ_reg;
    logic signed [pdc_pkg::INT_W-1:0]    integ_next;
    logic signed [pdc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [pdc_pkg::PROD_W-1:0]   prod_next;
    logic signed [pdc_pkg::ACC_W-1:0]    acc_reg;
    logic signed [pdc_pkg::ACC_W-1:0]    acc_next;
    logic                                out_valid_reg;
    logic signed [pdc_pkg::OUT_W-1:0]    drive_reg;
    logic signed [pdc_pkg::OUT_W-1:0]    drive_next;
    logic                                clamped_reg;
    logic                                clamped_next;

    pdc_pkg::ctrl_t                      ctrl;
    logic                                in_fire;
    logic                                step_go;
    logic                                step_last;
    logic                                cfg_wr;
    logic signed [16:0]                  mul_a;
    logic signed [20:0]                  mul_b;
    logic signed [17:0]                  de_w;
    logic signed [17:0]                  err_ext;
    logic [17:0]                         mag_w;
    logic                                exceed_w;
    logic signed [pdc_pkg::INT_W:0]      isum_w;
    logic signed [pdc_pkg::ACC_W-1:0]    prod_ext;
    logic signed [pdc_pkg::PROD_W-1:0]   dr_w;
    logic signed [pdc_pkg::PROD_W-1:0]   max_ext;
    logic signed [pdc_pkg::PROD_W-1:0]   min_ext;

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign s_axis_tready = !busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = drive_reg;
    assign m_axis_tuser  = clamped_reg;

    assign ctrl      = pdc_pkg::rom(pc_reg);
    assign step_last = (ctrl.act == pdc_pkg::ACT_OUT) || (ctrl.act == pdc_pkg::ACT_ZERO);
    assign step_go   = busy_reg && !(step_last && out_valid_reg && !m_axis_tready);

    // register read
    always_comb
    begin
        prdata = '0;
        unique case (pdc_pkg::reg_idx_t'(paddr[4:2]))
            pdc_pkg::REG_ENABLE:  prdata = {31'd0, enable_reg};
            pdc_pkg::REG_KP:      prdata = {16'd0, kp_reg};
            pdc_pkg::REG_KI:      prdata = {16'd0, ki_reg};
            pdc_pkg::REG_KD:      prdata = {16'd0, kd_reg};
            pdc_pkg::REG_DT:      prdata = {16'd0, dt_reg};
            pdc_pkg::REG_EPSILON: prdata = {16'd0, eps_reg};
            pdc_pkg::REG_OUT_MAX: prdata = 32'(out_max_reg);
            pdc_pkg::REG_OUT_MIN: prdata = 32'(out_min_reg);
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            dt_reg      <= 16'd6554;
            eps_reg     <= '0;
            out_max_reg <= 24'sd25600;
            out_min_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (pdc_pkg::reg_idx_t'(paddr[4:2]))
                pdc_pkg::REG_ENABLE:  enable_reg  <= pwdata[0];
                pdc_pkg::REG_KP:      kp_reg      <= pwdata[15:0];
                pdc_pkg::REG_KI:      ki_reg      <= pwdata[15:0];
                pdc_pkg::REG_KD:      kd_reg      <= pwdata[15:0];
                pdc_pkg::REG_DT:      dt_reg      <= pwdata[15:0];
                pdc_pkg::REG_EPSILON: eps_reg     <= pwdata[15:0];
                pdc_pkg::REG_OUT_MAX: out_max_reg <= $signed(pwdata[23:0]);
                pdc_pkg::REG_OUT_MIN: out_min_reg <= $signed(pwdata[23:0]);
                default:              enable_reg  <= enable_reg;
            endcase
        end
    end

    // shared datapath
    always_comb
    begin
        err_ext  = 18'(err_reg);
        de_w     = err_ext - 18'(last_err_reg);
        mag_w    = err_reg[pdc_pkg::ERR_W-1] ? 18'(-err_ext) : 18'(err_ext);
        exceed_w = mag_w > {2'b00, eps_reg};

        mul_a = $signed({1'b0, dt_reg});
        mul_b = 21'(err_reg);
        case (ctrl.mul)
            pdc_pkg::MUL_DT_ERR:
            begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = 21'(err_reg);
            end
            pdc_pkg::MUL_KP_ERR:
            begin
                mul_a = $signed({1'b0, kp_reg});
                mul_b = 21'(err_reg);
            end
            pdc_pkg::MUL_KD_DE:
            begin
                mul_a = $signed({1'b0, kd_reg});
                mul_b = 21'(de_w);
            end
            pdc_pkg::MUL_KI_LO:
            begin
                mul_a = $signed({1'b0, ki_reg});
                mul_b = $signed({1'b0, integ_reg[19:0]});
            end
            pdc_pkg::MUL_KI_HI:
            begin
                mul_a = $signed({1'b0, ki_reg});
                mul_b = $signed({integ_reg[39], integ_reg[39:20]});
            end
            default:
            begin
                mul_a = $signed({1'b0, dt_reg});
                mul_b = 21'(err_reg);
            end
        endcase
        prod_next = mul_a * mul_b;

        prod_ext = pdc_pkg::ACC_W'(prod_reg);
        case (ctrl.acc)
            pdc_pkg::ACC_CLR:   acc_next = '0;
            pdc_pkg::ACC_ADD0:  acc_next = acc_reg + prod_ext;
            pdc_pkg::ACC_ADD16: acc_next = acc_reg + (prod_ext <<< 16);
            pdc_pkg::ACC_ADD20: acc_next = acc_reg + (prod_ext <<< 20);
            default:            acc_next = acc_reg;
        endcase

        // saturating integral update
        isum_w = 41'(integ_reg) + 41'($signed(prod_reg[32:0]));
        if (isum_w[40] != isum_w[39])
            integ_next = isum_w[40] ? {1'b1, {(pdc_pkg::INT_W-1){1'b0}}}
                                    : {1'b0, {(pdc_pkg::INT_W-1){1'b1}}};
        else
            integ_next = isum_w[39:0];

        // floor shift to Q.8 and clamp, upper limit first
        dr_w    = $signed(acc_reg[pdc_pkg::ACC_W-1:20]);
        max_ext = pdc_pkg::PROD_W'(out_max_reg);
        min_ext = pdc_pkg::PROD_W'(out_min_reg);
        if (dr_w > max_ext)
        begin
            drive_next   = out_max_reg;
            clamped_next = 1'b1;
        end
        else if (dr_w < min_ext)
        begin
            drive_next   = out_min_reg;
            clamped_next = 1'b1;
        end
        else
        begin
            drive_next   = dr_w[pdc_pkg::OUT_W-1:0];
            clamped_next = 1'b0;
        end

        err_next      = 17'($signed(s_axis_tdata[15:0])) - 17'($signed(s_axis_tdata[31:16]));
        last_err_next = err_reg;

        if (ctrl.jmp == pdc_pkg::JMP_DIS && !enable_reg)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    // sequencer and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
        end
        else
        begin
            if (step_go && step_last)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (in_fire)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
                if (enable_reg && s_axis_tuser[0])
                begin
                    integ_reg    <= '0;
                    last_err_reg <= '0;
                end
            end
            else if (step_go)
            begin
                pc_reg <= pc_next;
                if (ctrl.act == pdc_pkg::ACT_INTEG && exceed_w)
                    integ_reg <= integ_next;
                if (ctrl.act == pdc_pkg::ACT_OUT)
                    last_err_reg <= last_err_next;
                if (step_last)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            err_reg <= err_next;
        if (step_go)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
            if (ctrl.act == pdc_pkg::ACT_OUT)
            begin
                drive_reg   <= drive_next;
                clamped_reg <= clamped_next;
            end
            else if (ctrl.act == pdc_pkg::ACT_ZERO)
            begin
                drive_reg   <= '0;
                clamped_reg <= 1'b0;
            end
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy_reg && pc_reg == '0)
        else $error("request accepted but program not started");

    a_last_step_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && step_last |=> out_valid_reg && !busy_reg)
        else $error("final step did not present a result");

    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        step_go && ctrl.act == pdc_pkg::ACT_ZERO |=> drive_reg == '0 && !clamped_reg)
        else $error("disabled result not zero");

    a_clamp_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && clamped_reg && !busy_reg |->
            drive_reg == out_max_reg || drive_reg == out_min_reg)
        else $error("clamp flag without a limit value");

    a_disabled_skips: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && pc_reg == '0 && !enable_reg && !in_fire |=> pc_reg == pdc_pkg::STEP_ZERO)
        else $error("disabled request ran the control program");

endmodule

// ===== verif/tb_pid_controller_deadband_clamp.sv =====
module tb_pid_controller_deadband_clamp;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     CLK_PERIOD  = 2;
    localparam int     STALL_LIMIT = 2000;
    localparam longint INTEG_MAX   = 64'sd549755813887;
    localparam longint INTEG_MIN   = -64'sd549755813888;

    typedef struct packed {
        logic [31:0] data;
        logic        clr;
    } req_t;

    typedef struct packed {
        logic [23:0] drive;
        logic        clamped;
    } drive_t;

    logic                        clk           = 1'b0;
    logic                        rst_n         = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [31:0]                 s_axis_tdata  = '0;  // [15:0] target, [31:16] measured
    logic [0:0]                  s_axis_tuser  = '0;  // [0] clear_history
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [23:0]                 m_axis_tdata;        // [23:0] drive
    logic [0:0]                  m_axis_tuser;        // [0] clamped
    logic                        psel          = 1'b0;
    logic                        penable       = 1'b0;
    logic                        pwrite        = 1'b0;
    logic [pdc_pkg::ADDR_W-1:0]  paddr         = '0;
    logic [31:0]                 pwdata        = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // controller copy: settings and loop history
    logic                en_r     = 1'b1;
    logic [15:0]         kp_r     = 16'd0;
    logic [15:0]         ki_r     = 16'd0;
    logic [15:0]         kd_r     = 16'd0;
    logic [15:0]         dt_r     = 16'd6554;
    logic [15:0]         eps_r    = 16'd0;
    logic signed [23:0]  omax_r   = 24'sd25600;
    logic signed [23:0]  omin_r   = 24'sd0;
    longint              integ_acc = 0;
    longint              prev_err  = 0;

    req_t                req_q[$];
    drive_t              drive_q[$];
    req_t                nxt_req;
    drive_t              nxt_drive;
    drive_t              want;

    bit                  idle_on   = 1'b1;
    bit                  hold_req  = 1'b0;
    int                  send_gap  = 0;
    int                  hold_left = 0;
    int                  stall_cycles = 0;
    int                  n_err   = 0;
    int                  n_req   = 0;
    int                  n_clamp = 0;
    int                  n_off   = 0;
    int                  n_sat   = 0;
    int                  n_cfg   = 0;

    pid_controller_deadband_clamp u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic drive_t pid_step(input logic [31:0] data, input logic clr);
        drive_t             r;
        logic signed [15:0] tgt;
        logic signed [15:0] msr;
        longint             err;
        longint             mag;
        longint             nxt;
        longint             acc;
        longint             outv;
        r = '0;
        tgt = data[15:0];
        msr = data[31:16];
        if (!en_r)
        begin
            n_off++;
            return r;
        end
        if (clr)
        begin
            integ_acc = 0;
            prev_err = 0;
        end
        err = longint'(tgt) - longint'(msr);
        mag = (err < 0) ? -err : err;
        if (mag > longint'(eps_r))
        begin
            nxt = integ_acc + err * longint'(dt_r);
            if (nxt > INTEG_MAX)
            begin
                nxt = INTEG_MAX;
                n_sat++;
            end
            else if (nxt < INTEG_MIN)
            begin
                nxt = INTEG_MIN;
                n_sat++;
            end
            integ_acc = nxt;
        end
        acc = (longint'(kp_r) * err + longint'(kd_r) * (err - prev_err)) * 65536
              + longint'(ki_r) * integ_acc;
        outv = acc >>> 20;
        if (outv > longint'(omax_r))
        begin
            outv = longint'(omax_r);
            r.clamped = 1'b1;
        end
        else if (outv < longint'(omin_r))
        begin
            outv = longint'(omin_r);
            r.clamped = 1'b1;
        end
        prev_err = err;
        r.drive = outv[23:0];
        if (r.clamped)
            n_clamp++;
        return r;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                nxt_drive = pid_step(s_axis_tdata, s_axis_tuser[0]);
                drive_q.push_back(nxt_drive);
                n_req++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (idle_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 3);
                    s_axis_tvalid <= 1'b0;
                end
                else if (req_q.size() > 0)
                begin
                    nxt_req = req_q.pop_front();
                    s_axis_tdata  <= nxt_req.data;
                    s_axis_tuser  <= nxt_req.clr;
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (drive_q.size() == 0)
                begin
                    $error("unexpected result: drive %h clamped %b",
                           m_axis_tdata, m_axis_tuser[0]);
                    n_err++;
                end
                else
                begin
                    want = drive_q.pop_front();
                    if (m_axis_tdata !== want.drive)
                    begin
                        $error("drive: expected %h, got %h", want.drive, m_axis_tdata);
                        n_err++;
                    end
                    if (m_axis_tuser[0] !== want.clamped)
                    begin
                        $error("clamped: expected %b, got %b", want.clamped, m_axis_tuser[0]);
                        n_err++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = 79;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic reg_write(input pdc_pkg::reg_idx_t idx, input int val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pdc_pkg::REG_ENABLE:  en_r   = val[0];
            pdc_pkg::REG_KP:      kp_r   = val[15:0];
            pdc_pkg::REG_KI:      ki_r   = val[15:0];
            pdc_pkg::REG_KD:      kd_r   = val[15:0];
            pdc_pkg::REG_DT:      dt_r   = val[15:0];
            pdc_pkg::REG_EPSILON: eps_r  = val[15:0];
            pdc_pkg::REG_OUT_MAX: omax_r = val[23:0];
            pdc_pkg::REG_OUT_MIN: omin_r = val[23:0];
            default: ;
        endcase
    endtask

    // wait until every request is through and its result has been taken
    task automatic settle();
        do
        begin
            while (!(req_q.size() == 0 && !s_axis_tvalid && drive_q.size() == 0))
                @(posedge clk);
            repeat (10) @(posedge clk);
        end
        while (!(req_q.size() == 0 && !s_axis_tvalid && drive_q.size() == 0));
    endtask

    function automatic void push_req(input int tgt, input int msr, input bit clr);
        req_t r;
        r.data = {16'(msr), 16'(tgt)};
        r.clr = clr;
        req_q.push_back(r);
    endfunction

    function automatic int pick_u16();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 65535;
            2, 3:    return $urandom_range(0, 65535);
            default: return $urandom_range(0, 512);
        endcase
    endfunction

    task automatic rand_config();
        int hi;
        int lo;
        int tmp;
        reg_write(pdc_pkg::REG_ENABLE, ($urandom_range(0, 7) == 0) ? 0 : 1);
        reg_write(pdc_pkg::REG_KP, pick_u16());
        reg_write(pdc_pkg::REG_KI, pick_u16());
        reg_write(pdc_pkg::REG_KD, pick_u16());
        reg_write(pdc_pkg::REG_DT, pick_u16());
        reg_write(pdc_pkg::REG_EPSILON,
                  ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64) : pick_u16());
        case ($urandom_range(0, 3))
            0:
            begin
                hi = 8388607;
                lo = -8388608;
            end
            1:
            begin
                hi = $urandom_range(0, 200000);
                lo = -int'($urandom_range(0, 200000));
            end
            2:
            begin
                hi = int'($urandom_range(0, 16777215)) - 8388608;
                lo = int'($urandom_range(0, 16777215)) - 8388608;
            end
            default:
            begin
                hi = 25600;
                lo = 0;
            end
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            tmp = hi;
            hi = lo;
            lo = tmp;
        end
        reg_write(pdc_pkg::REG_OUT_MAX, hi);
        reg_write(pdc_pkg::REG_OUT_MIN, lo);
        n_cfg++;
    endtask

    // mostly a loop tracking its setpoint, some unrelated requests
    function automatic void add_item(input int setp);
        if ($urandom_range(0, 4) != 0)
            push_req(setp, setp + int'($urandom_range(0, 256)) - 128,
                     $urandom_range(0, 39) == 0);
        else
            push_req($urandom, $urandom, $urandom_range(0, 3) == 0);
    endfunction

    initial
    begin
        int setp;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // deadband edge, sum equal to the limit, zero time step
        reg_write(pdc_pkg::REG_KP, 256);
        reg_write(pdc_pkg::REG_KI, 256);
        reg_write(pdc_pkg::REG_KD, 0);
        reg_write(pdc_pkg::REG_DT, 4096);
        reg_write(pdc_pkg::REG_EPSILON, 16);
        reg_write(pdc_pkg::REG_OUT_MAX, 1700);
        reg_write(pdc_pkg::REG_OUT_MIN, -1600);
        n_cfg++;
        push_req(0, 16, 1);
        push_req(100, 0, 0);
        settle();
        reg_write(pdc_pkg::REG_DT, 0);
        push_req(100, 0, 0);
        push_req(32767, -32768, 0);
        push_req(-32768, 32767, 0);
        settle();

        // every gain and the time step at full scale
        reg_write(pdc_pkg::REG_KP, 65535);
        reg_write(pdc_pkg::REG_KI, 65535);
        reg_write(pdc_pkg::REG_KD, 65535);
        reg_write(pdc_pkg::REG_DT, 65535);
        reg_write(pdc_pkg::REG_EPSILON, 0);
        reg_write(pdc_pkg::REG_OUT_MAX, 8388607);
        reg_write(pdc_pkg::REG_OUT_MIN, -8388608);
        n_cfg++;
        push_req(32767, -32768, 0);
        push_req(-32768, 32767, 0);
        push_req(32767, 32767, 1);
        push_req(1, 0, 0);
        push_req(0, 1, 0);
        push_req(-1, -1, 0);
        settle();

        // crossed limits
        reg_write(pdc_pkg::REG_KI, 0);
        reg_write(pdc_pkg::REG_KD, 0);
        reg_write(pdc_pkg::REG_KP, 256);
        reg_write(pdc_pkg::REG_OUT_MAX, -100);
        reg_write(pdc_pkg::REG_OUT_MIN, 100);
        n_cfg++;
        push_req(0, 0, 1);
        push_req(-50, 0, 0);
        push_req(10, 0, 0);
        settle();

        // disabled: history must survive a clear request
        reg_write(pdc_pkg::REG_KD, 300);
        reg_write(pdc_pkg::REG_ENABLE, 0);
        push_req(500, 0, 1);
        push_req(-32768, 32767, 1);
        settle();
        reg_write(pdc_pkg::REG_ENABLE, 1);
        push_req(0, 0, 0);
        settle();

        // drive the integral into both saturation limits
        reg_write(pdc_pkg::REG_KP, 0);
        reg_write(pdc_pkg::REG_KD, 0);
        reg_write(pdc_pkg::REG_KI, 1);
        reg_write(pdc_pkg::REG_DT, 65535);
        reg_write(pdc_pkg::REG_EPSILON, 0);
        reg_write(pdc_pkg::REG_OUT_MAX, 8388607);
        reg_write(pdc_pkg::REG_OUT_MIN, -8388608);
        n_cfg++;
        push_req(0, 0, 1);
        repeat (140)
            push_req(32767 - int'($urandom_range(0, 7)), -32768 + int'($urandom_range(0, 7)), 0);
        repeat (140)
            push_req(-32768 + int'($urandom_range(0, 7)), 32767 - int'($urandom_range(0, 7)), 0);
        settle();

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph >= 10)
                idle_on = 1'b0;
            rand_config();
            if (ph == 3)
                reg_write(pdc_pkg::REG_ENABLE, 0);
            if (ph == 5)
                hold_req = 1'b1;
            setp = $urandom_range(0, 65535);
            for (int i = 0; i < 130; i++)
            begin
                if ($urandom_range(0, 31) == 0)
                    setp = $urandom_range(0, 65535);
                add_item(setp);
                if (ph == 7 && i == 64)
                    settle();
            end
            settle();
        end

        repeat (16) @(posedge clk);
        $display("covered %0d requests over %0d settings: %0d clamped, %0d while disabled",
                 n_req, n_cfg, n_clamp, n_off);
        $display("integral hit its 40-bit limit %0d times", n_sat);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
